// ----- hdl/mvtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mvtc_pkg
// Shared constants and control types for the matrix-vector threshold block.
// ----------------------------------------------------------------------------
`default_nettype none

package mvtc_pkg;

   localparam int DIM_MAX_DEF    = 16;
   localparam int DATA_WIDTH_DEF = 16;

   localparam int ACC_W       = 40;
   localparam int THR_W       = 39;
   localparam int LEN_CFG_W   = 5;
   localparam int IDX_FIELD_W = 4;

   localparam logic [LEN_CFG_W-1:0] LEN_RESET = LEN_CFG_W'(16);

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 64;

   // register select, taken from paddr[3]
   localparam logic REG_LEN = 1'b0;
   localparam logic REG_THR = 1'b1;

   localparam int RSP_TDATA_W = ((IDX_FIELD_W + ACC_W + 7) / 8) * 8;

   typedef struct packed {
      logic load_mat;
      logic load_vec;
      logic start;
      logic mac_valid;
      logic mac_first;
      logic mac_last;
      logic emit;
      logic emit_last;
   } mvtc_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } mvtc_status_type;

endpackage

`default_nettype wire

// ----- hdl/mvtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mvtc_ctrl
// Sequencer: input acceptance, MAC address walk, pipeline drain, result emit.
// ----------------------------------------------------------------------------
`default_nettype none

module mvtc_ctrl import mvtc_pkg::*; #(
   parameter int DIM_MAX = DIM_MAX_DEF,
   localparam int IDX_W = $clog2(DIM_MAX)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_accept,
   input  wire logic                   in_mode,
   input  wire logic [IDX_FIELD_W-1:0] in_col,
   input  wire logic [IDX_W-1:0]       last_idx,
   input  wire mvtc_status_type        status,
   output mvtc_cmd_type                cmd,
   output logic [IDX_W-1:0]            mac_row,
   output logic [IDX_W-1:0]            mac_col,
   output logic [IDX_W-1:0]            emit_idx,
   output logic                        in_ready
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] l_ff, l_in;
   logic [IDX_W-1:0] e_ff, e_in;
   logic             col_ok;
   logic             trigger;

   assign col_ok  = 32'(in_col) < DIM_MAX;
   assign trigger = in_accept & in_mode & (32'(in_col) == 32'(last_idx));

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      l_in     = l_ff;
      e_in     = e_ff;
      cmd      = '0;
      cmd.load_mat = in_accept & ~in_mode;
      cmd.load_vec = in_accept & in_mode & col_ok;
      unique case (state_ff)
         ST_IDLE: begin
            if (trigger) begin
               state_in  = ST_MAC;
               k_in      = '0;
               l_in      = '0;
               cmd.start = 1'b1;
            end
         end
         ST_MAC: begin
            cmd.mac_valid = 1'b1;
            cmd.mac_first = (l_ff == '0);
            cmd.mac_last  = (l_ff == last_idx);
            if (l_ff == last_idx) begin
               l_in = '0;
               k_in = k_ff + 1'b1;
               if (k_ff == last_idx) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               l_in = l_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_EMIT;
               e_in     = '0;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = (e_ff == last_idx);
               if (e_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  e_in = e_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         l_ff     <= '0;
         e_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         l_ff     <= l_in;
         e_ff     <= e_in;
      end
   end

   assign mac_row  = k_ff;
   assign mac_col  = l_ff;
   assign emit_idx = e_ff;
   assign in_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ----- hdl/mvtc_dpath.sv -----
// ----------------------------------------------------------------------------
// mvtc_dpath
// Matrix memory, vector registers, MAC pipeline, result store, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mvtc_dpath import mvtc_pkg::*; #(
   parameter int DIM_MAX    = DIM_MAX_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int IDX_W = $clog2(DIM_MAX)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mvtc_cmd_type           cmd,
   input  wire logic [IDX_FIELD_W-1:0] in_row,
   input  wire logic [IDX_FIELD_W-1:0] in_col,
   input  wire logic [DATA_WIDTH-1:0]  in_value,
   input  wire logic [IDX_W-1:0]       mac_row,
   input  wire logic [IDX_W-1:0]       mac_col,
   input  wire logic [IDX_W-1:0]       emit_idx,
   input  wire logic [THR_W-1:0]       threshold,
   output mvtc_status_type             status,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tvalid,
   output logic [IDX_FIELD_W-1:0]      rsp_index,
   output logic [ACC_W-1:0]            rsp_value,
   output logic                        rsp_last
);

   localparam int MAT_DEPTH = DIM_MAX * DIM_MAX;
   localparam int ADDR_W    = $clog2(MAT_DEPTH);
   localparam int PROD_W    = 2 * DATA_WIDTH;

   logic [DATA_WIDTH-1:0] mat_mem [MAT_DEPTH];
   logic [DATA_WIDTH-1:0] vec_ff  [DIM_MAX];
   logic [ACC_W-1:0]      res_ff  [DIM_MAX];

   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  mat_ok;

   logic                  s1_v_ff, s1_first_ff, s1_last_ff;
   logic [IDX_W-1:0]      s1_row_ff;
   logic [DATA_WIDTH-1:0] mat_rd_ff;
   logic [DATA_WIDTH-1:0] vec_rd_ff;

   logic                  s2_v_ff, s2_first_ff, s2_last_ff;
   logic [IDX_W-1:0]      s2_row_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic [ACC_W-1:0]      acc_ff;
   logic [ACC_W-1:0]      acc_sum;
   logic                  above;
   logic                  all_above_ff;

   logic                  rsp_valid_ff;
   logic [IDX_FIELD_W-1:0] rsp_index_ff;
   logic [ACC_W-1:0]      rsp_value_ff;
   logic                  rsp_last_ff;

   assign mat_ok  = (32'(in_row) < DIM_MAX) && (32'(in_col) < DIM_MAX);
   assign wr_addr = ADDR_W'(32'(in_row) * DIM_MAX + 32'(in_col));
   assign rd_addr = ADDR_W'(32'(mac_row) * DIM_MAX + 32'(mac_col));

   always_ff @(posedge clock) begin
      if (cmd.load_mat && mat_ok) begin
         mat_mem[wr_addr] <= in_value;
      end
      mat_rd_ff <= mat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_vec) begin
         vec_ff[IDX_W'(in_col)] <= in_value;
      end
      vec_rd_ff <= vec_ff[mac_col];
      s1_first_ff <= cmd.mac_first;
      s1_last_ff  <= cmd.mac_last;
      s1_row_ff   <= mac_row;
      prod_ff     <= $signed(mat_rd_ff) * $signed(vec_rd_ff);
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_row_ff   <= s1_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.mac_valid;
         s2_v_ff <= s1_v_ff;
      end
   end

   assign acc_sum = (s2_first_ff ? '0 : acc_ff) + ACC_W'($signed(prod_ff));
   assign above   = $signed(acc_sum) > $signed({1'b0, threshold});

   always_ff @(posedge clock) begin
      if (s2_v_ff) begin
         acc_ff <= acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIM_MAX; i++) begin
            res_ff[i] <= '0;
         end
      end else if (s2_v_ff && s2_last_ff) begin
         res_ff[s2_row_ff] <= acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         all_above_ff <= 1'b1;
      end else begin
         priority if (cmd.start) begin
            all_above_ff <= 1'b1;
         end else if (s2_v_ff && s2_last_ff) begin
            all_above_ff <= all_above_ff & above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_index_ff <= IDX_FIELD_W'(emit_idx);
         rsp_value_ff <= all_above_ff ? '0 : res_ff[emit_idx];
         rsp_last_ff  <= cmd.emit_last;
      end
   end

   assign status.pipe_busy = s1_v_ff | s2_v_ff;
   assign status.out_free  = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hdl/matvec_threshold_clear.sv -----
// Requests are taken only while the sequencer is idle; a matrix entry or a
// non-final vector element is just stored. The vector element with index n-1
// starts the MAC walk over all n*n entries on one shared multiplier, then the
// pipeline drains and results are emitted one per cycle while rsp_tready holds.
// Reset clears the control state, the result store, length 16, threshold 0;
// matrix and vector stores are undefined until written.
// ----------------------------------------------------------------------------
// matvec_threshold_clear
// Matrix-vector multiply with clear of the result when all elements exceed
// a threshold. Stream in/out, APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none

module matvec_threshold_clear import mvtc_pkg::*; #(
   parameter int DIM_MAX    = DIM_MAX_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int REQ_TDATA_W = ((2 * IDX_FIELD_W + DATA_WIDTH + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // row, col, value
   input  wire logic                   req_tuser,   // mode

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // out_index, out_value
   output logic                        rsp_tlast,

   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_AW-1:0]      csr_paddr,
   input  wire logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]           csr_prdata,
   output logic                        csr_pready
);

   localparam int IDX_W = $clog2(DIM_MAX);
   localparam int LEN_W = $clog2(DIM_MAX + 1);

   logic [LEN_CFG_W-1:0]   len_ff;
   logic [THR_W-1:0]       thr_ff;
   logic                   csr_wr;
   logic [LEN_W-1:0]       eff_len;
   logic [IDX_W-1:0]       last_idx;

   logic                   req_accept;
   logic [IDX_FIELD_W-1:0] req_row;
   logic [IDX_FIELD_W-1:0] req_col;
   logic [DATA_WIDTH-1:0]  req_value;

   mvtc_cmd_type           cmd;
   mvtc_status_type        status;
   logic [IDX_W-1:0]       mac_row;
   logic [IDX_W-1:0]       mac_col;
   logic [IDX_W-1:0]       emit_idx;
   logic [IDX_FIELD_W-1:0] rsp_index;
   logic [ACC_W-1:0]       rsp_value;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
         thr_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[3] == REG_LEN) begin
            len_ff <= csr_pwdata[LEN_CFG_W-1:0];
         end else begin
            thr_ff <= csr_pwdata[THR_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[3] == REG_THR) ? CSR_DW'(thr_ff) : CSR_DW'(len_ff);

   always_comb begin
      if (len_ff < LEN_CFG_W'(2)) begin
         eff_len = LEN_W'(2);
      end else if (32'(len_ff) > DIM_MAX) begin
         eff_len = LEN_W'(DIM_MAX);
      end else begin
         eff_len = LEN_W'(len_ff);
      end
   end

   assign last_idx = IDX_W'(eff_len - LEN_W'(1));

   assign req_accept = req_tvalid & req_tready;
   assign req_row    = req_tdata[IDX_FIELD_W-1:0];
   assign req_col    = req_tdata[2*IDX_FIELD_W-1:IDX_FIELD_W];
   assign req_value  = req_tdata[2*IDX_FIELD_W +: DATA_WIDTH];

   mvtc_ctrl #(
      .DIM_MAX (DIM_MAX)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_mode   (req_tuser),
      .in_col    (req_col),
      .last_idx  (last_idx),
      .status    (status),
      .cmd       (cmd),
      .mac_row   (mac_row),
      .mac_col   (mac_col),
      .emit_idx  (emit_idx),
      .in_ready  (req_tready)
   );

   mvtc_dpath #(
      .DIM_MAX    (DIM_MAX),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_row     (req_row),
      .in_col     (req_col),
      .in_value   (req_value),
      .mac_row    (mac_row),
      .mac_col    (mac_col),
      .emit_idx   (emit_idx),
      .threshold  (thr_ff),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_index  (rsp_index),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_value, rsp_index});

`ifndef ASSERT_OFF
   a_no_accept_in_mac: assert property (@(posedge clock) disable iff (reset)
      cmd.mac_valid |-> !req_tready)
      else $error("transaction accepted during MAC sequence");

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result emitted over a pending transaction");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_last) |=> (rsp_tvalid && rsp_tlast))
      else $error("final result not marked last");
`endif

endmodule

`default_nettype wire

// ----- bench/mvtc_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// mvtc_tb_pkg
// Request mode codes shared by the matvec_threshold_clear bench and checker.
// ----------------------------------------------------------------------------
package mvtc_tb_pkg;

   typedef enum logic {
      MODE_MATRIX = 1'b0,
      MODE_VECTOR = 1'b1
   } mvtc_mode_type;

endpackage

// ----- bench/mvtc_checker.sv -----
// ----------------------------------------------------------------------------
// mvtc_checker
// Passive monitor for matvec_threshold_clear. Follows register writes and
// request transactions, keeps its own copy of matrix and vector, forms
// y = M*x with the threshold clear on every trigger and compares each
// response transaction and register read against it.
// ----------------------------------------------------------------------------
module mvtc_checker import mvtc_pkg::*, mvtc_tb_pkg::*; #(
   parameter int DIM_MAX     = DIM_MAX_DEF,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
   parameter int REQ_TDATA_W = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // row, col, value
   input  wire logic                   req_tuser,   // mode
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_index, out_value
   input  wire logic                   rsp_tlast,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_AW-1:0]      csr_paddr,
   input  wire logic [CSR_DW-1:0]      csr_pwdata,
   input  wire logic [CSR_DW-1:0]      csr_prdata,
   input  wire logic                   csr_pready,
   output int                          errors,
   output int                          y_outstanding,
   output int                          vectors_formed,
   output int                          vectors_cleared
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0] index;
      logic [ACC_W-1:0]       value;
      logic                   last;
   } y_elem_type;

   logic signed [DATA_WIDTH-1:0] coef   [DIM_MAX][DIM_MAX];
   logic signed [DATA_WIDTH-1:0] x_elem [DIM_MAX];
   logic [LEN_CFG_W-1:0]         len_reg = LEN_RESET;
   logic [THR_W-1:0]             thr_reg = '0;
   y_elem_type                   y_due[$];
   int                           err_cnt = 0;
   int                           formed_cnt = 0;
   int                           cleared_cnt = 0;

   function automatic int eff_len();
      if (len_reg < 2) return 2;
      if (len_reg > DIM_MAX) return DIM_MAX;
      return int'(len_reg);
   endfunction

   function automatic void form_y();
      int                      n;
      bit                      all_above;
      longint                  sum;
      logic signed [ACC_W-1:0] y [DIM_MAX];
      y_elem_type              e;
      n = eff_len();
      all_above = 1'b1;
      for (int k = 0; k < n; k++) begin
         sum = 0;
         for (int j = 0; j < n; j++)
            sum += longint'(coef[k][j]) * longint'(x_elem[j]);
         y[k] = sum[ACC_W-1:0];
         if (!(y[k] > $signed({1'b0, thr_reg})))
            all_above = 1'b0;
      end
      formed_cnt++;
      if (all_above)
         cleared_cnt++;
      for (int k = 0; k < n; k++) begin
         e.index = IDX_FIELD_W'(k);
         e.value = all_above ? '0 : y[k];
         e.last  = (k == n - 1);
         y_due.push_back(e);
      end
   endfunction

   function automatic void take_request();
      logic [IDX_FIELD_W-1:0] row;
      logic [IDX_FIELD_W-1:0] col;
      logic [DATA_WIDTH-1:0]  value;
      row   = req_tdata[IDX_FIELD_W-1:0];
      col   = req_tdata[IDX_FIELD_W +: IDX_FIELD_W];
      value = req_tdata[2*IDX_FIELD_W +: DATA_WIDTH];
      if (req_tuser == MODE_MATRIX) begin
         coef[row][col] = value;
      end else begin
         x_elem[col] = value;
         if (int'(col) == eff_len() - 1)
            form_y();
      end
   endfunction

   function automatic void check_y();
      y_elem_type              e;
      logic [IDX_FIELD_W-1:0]  idx;
      logic signed [ACC_W-1:0] val;
      idx = rsp_tdata[IDX_FIELD_W-1:0];
      val = rsp_tdata[IDX_FIELD_W +: ACC_W];
      if (y_due.size() == 0) begin
         err_cnt++;
         $display("%t unexpected result: index %0d value %0d last %0b",
                  $time, idx, val, rsp_tlast);
         return;
      end
      e = y_due.pop_front();
      if (idx !== e.index) begin
         err_cnt++;
         $display("%t out_index mismatch: expected %0d actual %0d", $time, e.index, idx);
      end
      if (val !== e.value) begin
         err_cnt++;
         $display("%t out_value mismatch at index %0d: expected %0d actual %0d",
                  $time, e.index, $signed(e.value), val);
      end
      if (rsp_tlast !== e.last) begin
         err_cnt++;
         $display("%t out_last mismatch at index %0d: expected %0b actual %0b",
                  $time, e.index, e.last, rsp_tlast);
      end
   endfunction

   function automatic void csr_transaction();
      logic [CSR_DW-1:0] want;
      if (csr_pwrite) begin
         case (csr_paddr[3])
            REG_LEN: len_reg = csr_pwdata[LEN_CFG_W-1:0];
            REG_THR: thr_reg = csr_pwdata[THR_W-1:0];
         endcase
      end else begin
         want = (csr_paddr[3] == REG_LEN) ? CSR_DW'(len_reg) : CSR_DW'(thr_reg);
         if (csr_prdata !== want) begin
            err_cnt++;
            $display("%t register read at 0x%0h: expected 0x%0h actual 0x%0h",
                     $time, csr_paddr, want, csr_prdata);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         y_due.delete();
         len_reg = LEN_RESET;
         thr_reg = '0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_y();
         if (req_tvalid && req_tready)
            take_request();
         if (csr_psel && csr_penable && csr_pready)
            csr_transaction();
      end
      errors          <= err_cnt;
      y_outstanding   <= y_due.size();
      vectors_formed  <= formed_cnt;
      vectors_cleared <= cleared_cnt;
   end

endmodule

// ----- bench/tb_matvec_threshold_clear.sv -----
// ----------------------------------------------------------------------------
// tb_matvec_threshold_clear
// Stimulus and verdict for matvec_threshold_clear. A directed opening covers
// the threshold tie and clear, retrigger, length saturation and extreme
// values; random phases then vary length, threshold, value bias and idling
// on both streams, including a long response stall. Checking is done by
// mvtc_checker.
// ----------------------------------------------------------------------------
module tb_matvec_threshold_clear import mvtc_pkg::*, mvtc_tb_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_TDATA_W   = ((2 * IDX_FIELD_W + DATA_WIDTH_DEF + 7) / 8) * 8;
   localparam int RESET_CYCLES  = 7;
   localparam int GAP_MAX       = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int END_CYCLES    = 300;
   localparam int IDLE_LIMIT    = 5000;
   localparam int RANDOM_ITEMS  = 200;

   localparam logic [CSR_AW-1:0]         ADDR_LEN = {REG_LEN, 3'b000};
   localparam logic [CSR_AW-1:0]         ADDR_THR = {REG_THR, 3'b000};
   localparam logic [THR_W-1:0]          THR_MAX  = '1;
   localparam logic [DATA_WIDTH_DEF-1:0] ONE_Q88  = 16'h0100;
   localparam logic [DATA_WIDTH_DEF-1:0] MIN_Q88  = 16'h8000;
   localparam logic [DATA_WIDTH_DEF-1:0] MAX_Q88  = 16'h7fff;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tuser   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr   = '0;
   logic [CSR_DW-1:0]      csr_pwdata  = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   int errors;
   int y_outstanding;
   int vectors_formed;
   int vectors_cleared;

   bit                   mat_set [16][16];
   bit                   vec_set [16];
   logic [LEN_CFG_W-1:0] len_now = LEN_RESET;
   bit                   tx_steady = 1'b0;
   bit                   rx_steady = 1'b0;
   int                   hold_requests = 0;
   int                   hold_served = 0;
   int                   idle_cycles = 0;
   int                   items_sent = 0;
   int                   directed_items;
   int                   phase_cnt = 0;
   int                   n;
   int                   reps;
   bit                   positive;
   logic [LEN_CFG_W-1:0] len_raw;
   logic [THR_W-1:0]     thr;

   matvec_threshold_clear dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mvtc_checker #(.REQ_TDATA_W(REQ_TDATA_W)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .errors          (errors),
      .y_outstanding   (y_outstanding),
      .vectors_formed  (vectors_formed),
      .vectors_cleared (vectors_cleared)
   );

   always #5ns clock = ~clock;

   // watchdog: cycles without any transaction on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%t no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random stall per transaction, or a long hold on request
   initial begin : rsp_drive
      int stall;
      while (reset) @(negedge clock);
      forever begin
         if (hold_served != hold_requests) begin
            stall = HOLD_CYCLES;
            hold_served++;
         end else if (rx_steady) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, GAP_MAX);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   function automatic logic [DATA_WIDTH_DEF-1:0] rand_value(input bit pos);
      return pos ? DATA_WIDTH_DEF'($urandom_range(0, 1023)) : DATA_WIDTH_DEF'($urandom);
   endfunction

   task automatic send_item(input mvtc_mode_type mode, input int row, input int col,
                            input logic [DATA_WIDTH_DEF-1:0] value);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {value, IDX_FIELD_W'(col), IDX_FIELD_W'(row)};
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_MATRIX)
         mat_set[row][col] = 1'b1;
      else
         vec_set[col] = 1'b1;
      items_sent++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (y_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_AW-1:0] addr,
                             input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (wr && addr == ADDR_LEN)
         len_now = data[LEN_CFG_W-1:0];
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed: reset values, threshold tie, clear on retrigger
      csr_access(1'b0, ADDR_LEN, '0);
      csr_access(1'b0, ADDR_THR, '0);
      csr_access(1'b1, ADDR_LEN, 64'd2);
      csr_access(1'b1, ADDR_THR, 64'd65536);
      send_item(MODE_MATRIX, 0, 0, ONE_Q88);
      send_item(MODE_MATRIX, 0, 1, '0);
      send_item(MODE_MATRIX, 1, 0, '0);
      send_item(MODE_MATRIX, 1, 1, ONE_Q88);
      send_item(MODE_VECTOR, 0, 0, ONE_Q88);
      send_item(MODE_VECTOR, 15, 1, ONE_Q88);
      wait_drain();
      csr_access(1'b1, ADDR_THR, 64'd65535);
      send_item(MODE_VECTOR, 0, 1, ONE_Q88);
      wait_drain();

      // length 0 saturates to 2; extreme coefficients, element beyond length
      csr_access(1'b1, ADDR_LEN, '0);
      csr_access(1'b1, ADDR_THR, '0);
      send_item(MODE_MATRIX, 15, 15, MAX_Q88);
      send_item(MODE_MATRIX, 0, 0, MIN_Q88);
      send_item(MODE_MATRIX, 0, 1, MIN_Q88);
      send_item(MODE_MATRIX, 1, 0, MAX_Q88);
      send_item(MODE_MATRIX, 1, 1, MIN_Q88);
      send_item(MODE_VECTOR, 0, 15, MAX_Q88);
      send_item(MODE_VECTOR, 0, 0, MIN_Q88);
      send_item(MODE_VECTOR, 15, 1, MAX_Q88);
      send_item(MODE_VECTOR, 15, 1, MIN_Q88);
      directed_items = items_sent;

      while (items_sent - directed_items < RANDOM_ITEMS) begin
         phase_cnt++;
         case ($urandom_range(0, 9))
            0:       len_raw = LEN_CFG_W'($urandom_range(0, 1));
            1:       len_raw = LEN_CFG_W'($urandom_range(16, 31));
            2:       len_raw = LEN_CFG_W'(2);
            default: len_raw = LEN_CFG_W'($urandom_range(3, 6));
         endcase
         case ($urandom_range(0, 3))
            0:       thr = '0;
            1:       thr = THR_MAX;
            2:       thr = THR_W'($urandom_range(0, 1 << 20));
            default: thr = THR_W'({$urandom, $urandom});
         endcase
         if (phase_cnt == 1)
            thr = THR_MAX;
         if (phase_cnt == 5)
            len_raw = 5'd31;
         positive  = $urandom_range(0, 1);
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         reps      = $urandom_range(2, 4);

         wait_drain();
         csr_access(1'b1, ADDR_LEN, {$urandom, 27'($urandom), len_raw});
         csr_access(1'b1, ADDR_THR, {25'($urandom), thr});
         if ($urandom_range(0, 3) == 0) begin
            csr_access(1'b0, ADDR_LEN, '0);
            csr_access(1'b0, ADDR_THR, '0);
         end
         n = (len_now < 2) ? 2 : (len_now > 16) ? 16 : int'(len_now);

         // long response stall while requests keep coming
         if (phase_cnt == 2) begin
            hold_requests++;
            tx_steady = 1'b1;
            reps = 4;
         end

         for (int k = 0; k < n; k++)
            for (int j = 0; j < n; j++)
               if (!mat_set[k][j])
                  send_item(MODE_MATRIX, k, j, rand_value(positive));

         for (int r = 0; r < reps; r++) begin
            if (phase_cnt == 3 && r == 1)
               wait_drain();
            if ($urandom_range(0, 2) == 0)
               send_item(MODE_MATRIX, $urandom_range(0, 15), $urandom_range(0, 15),
                         rand_value(positive));
            for (int j = 0; j < n; j++) begin
               if (j == n - 1 && n < 16 && $urandom_range(0, 3) == 0)
                  send_item(MODE_VECTOR, $urandom_range(0, 15), $urandom_range(n, 15),
                            rand_value(1'b0));
               send_item(MODE_VECTOR, $urandom_range(0, 15), j, rand_value(positive));
            end
            // retrigger on partly stale vector
            if ($urandom_range(0, 2) == 0)
               send_item(MODE_VECTOR, $urandom_range(0, 15), n - 1, rand_value(positive));
         end
      end

      wait_drain();
      repeat (END_CYCLES) @(posedge clock);
      $display("Sent %0d requests in %0d random phases after a directed opening.",
               items_sent, phase_cnt);
      $display("Formed %0d result vectors, %0d of them cleared by the threshold.",
               vectors_formed, vectors_cleared);
      if (errors == 0 && y_outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/mvtc_pkg.sv
hdl/mvtc_ctrl.sv
hdl/mvtc_dpath.sv
hdl/matvec_threshold_clear.sv
bench/mvtc_tb_pkg.sv
bench/mvtc_checker.sv
bench/tb_matvec_threshold_clear.sv
